// ===== design/fpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fixed-point multiply/divide package
// shared types and constants for the cell chain
// ----------------------------------------------------------------------------
package fpmd_pkg;

    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = 33;
    localparam int FRAC_BITS = 28;
    localparam int SCAL_BITS = 16;
    localparam int NUM_W     = 64;
    localparam int CELLS     = 64;
    localparam int IDX_W     = 6;

    localparam logic [OP_W-1:0] OP_MAKE_FRAC = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE_FRAC = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE_SCAL = 2'd2;
    localparam logic [OP_W-1:0] OP_MAKE_SCAL = 2'd3;

    localparam logic [MAG_W-1:0] MAXV = 33'h0_7FFF_FFFF;

    // one beat of work travelling down the chain
    typedef struct packed {
        logic             valid;
        logic             is_make;
        logic             neg;
        logic             ovf;
        logic [4:0]       k;        // 28 or 16
        logic [NUM_W-1:0] num;      // make: dividend shifted (consumed msb first)
        logic [MAG_W-1:0] div;      // make: |b|; take: |b|
        logic [MAG_W:0]   rem;      // make: partial remainder
        logic [NUM_W-1:0] quo;      // make: quotient bits; take: p in low bits
        logic [31:0]      fbits;    // take: fraction bits with leading one
        logic [MAG_W-1:0] ipart;    // take: integer part product (saturated)
    } fpmd_work_t;

endpackage

// ===== design/fpmd_cell.sv =====
// ----------------------------------------------------------------------------
// fpmd cell
// one step of restoring division or of the halving recurrence, registered
// ----------------------------------------------------------------------------
module fpmd_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [fpmd_pkg::IDX_W-1:0] idx,
    input  fpmd_pkg::fpmd_work_t d,
    output fpmd_pkg::fpmd_work_t q
);

    fpmd_pkg::fpmd_work_t    w_next;
    logic [fpmd_pkg::MAG_W:0] trial;
    logic [fpmd_pkg::MAG_W:0] sub;
    logic [fpmd_pkg::MAG_W:0] psum;
    logic [fpmd_pkg::IDX_W-1:0] base;

    always_comb
    begin
        w_next = d;
        base   = fpmd_pkg::IDX_W'(fpmd_pkg::NUM_W - 1) - idx;
        trial  = {d.rem[fpmd_pkg::MAG_W-1:0], d.num[base]};
        sub    = trial - {1'b0, d.div};
        psum   = {1'b0, d.quo[fpmd_pkg::MAG_W-1:0]} + {1'b0, d.div};
        if (d.is_make)
        begin
            // restoring division, one quotient bit per cell
            if (!sub[fpmd_pkg::MAG_W])
            begin
                w_next.rem = sub;
                w_next.quo = {d.quo[fpmd_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                w_next.rem = trial;
                w_next.quo = {d.quo[fpmd_pkg::NUM_W-2:0], 1'b0};
            end
        end
        else if ({1'b0, idx} < {2'b0, d.k})
        begin
            // halving step, lsb of fraction first
            if (d.fbits[0])
                w_next.quo = fpmd_pkg::NUM_W'(psum[fpmd_pkg::MAG_W:1]);
            else
                w_next.quo = {1'b0, d.quo[fpmd_pkg::NUM_W-1:1]};
            w_next.fbits = {1'b0, d.fbits[31:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= w_next;
    end

endmodule

// ===== design/fpmd_front.sv =====
// ----------------------------------------------------------------------------
// fpmd front end
// operand magnitudes, sign, early overflow and integer part
// ----------------------------------------------------------------------------
module fpmd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [fpmd_pkg::OP_W-1:0]  operation,
    input  logic signed [fpmd_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpmd_pkg::DATA_W-1:0] operand_b,
    output fpmd_pkg::fpmd_work_t q
);

    fpmd_pkg::fpmd_work_t w;
    logic [fpmd_pkg::MAG_W-1:0] ma;
    logic [fpmd_pkg::MAG_W-1:0] mb;
    logic        na;
    logic        nb;
    logic        mk;
    logic [4:0]  k;
    logic [fpmd_pkg::MAG_W-1:0] ip;
    logic [fpmd_pkg::MAG_W-1:0] fmask;

    always_comb
    begin
        na = operand_a[31];
        nb = operand_b[31];
        ma = na ? (33'h1_0000_0000 - {1'b0, operand_a}) : {1'b0, operand_a};
        mb = nb ? (33'h1_0000_0000 - {1'b0, operand_b}) : {1'b0, operand_b};
        mk = (operation == fpmd_pkg::OP_MAKE_FRAC) || (operation == fpmd_pkg::OP_MAKE_SCAL);
        k  = ((operation == fpmd_pkg::OP_MAKE_FRAC) || (operation == fpmd_pkg::OP_TAKE_FRAC))
             ? 5'd28 : 5'd16;
        ip    = ma >> k;
        fmask = (33'd1 << k) - 33'd1;
        w = '0;
        w.valid   = in_valid;
        w.is_make = mk;
        w.k       = k;
        w.div     = mb;
        w.ipart   = ip;
        if (mk)
        begin
            w.neg = na ^ (nb || (mb == '0));
            // quotient must stay below 2^(31-k): |a| < |b|*2^(31-k)
            w.ovf = (mb == '0) || (({31'd0, mb} << (5'd31 - k)) <= {31'd0, ma});
            w.num = {31'd0, ma} << k;
        end
        else
        begin
            w.neg   = na ^ nb;
            w.fbits = 32'(ma & fmask) | (32'd1 << k);
            w.quo   = 64'd1 << (k - 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= w;
    end

endmodule

// ===== design/fpmd_mult.sv =====
// ----------------------------------------------------------------------------
// fpmd integer part multiplier
// integer part of |a| times |b| with saturation, one registered stage
// ----------------------------------------------------------------------------
module fpmd_mult
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fpmd_pkg::fpmd_work_t d,
    output fpmd_pkg::fpmd_work_t q
);

    fpmd_pkg::fpmd_work_t w;
    logic [48:0] prod;

    always_comb
    begin
        w    = d;
        prod = 49'(d.ipart[15:0]) * 49'(d.div);
        if (!d.is_make)
        begin
            if (prod > 49'(fpmd_pkg::MAXV))
            begin
                w.ovf   = 1'b1;
                w.ipart = fpmd_pkg::MAXV;
            end
            else
            begin
                w.ipart = fpmd_pkg::MAG_W'(prod);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= w;
    end

endmodule

// ===== design/fixed_point_mul_div_unit.sv =====
// ----------------------------------------------------------------------------
// fixed-point multiply/divide unit
// make/take fraction and scaled arithmetic on a chain of bit cells
// the path from the accepting edge to the output beat holds 67 register stages
// throughput: one beat per cycle, the whole chain advances when the output is free
// the chain is front stage, multiplier stage, 64 bit cells and a finishing stage
// reset clears all valid bits and the sticky error flag
// ----------------------------------------------------------------------------
module fixed_point_mul_div_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result_value, overflow, error_sticky, zero pad
);

    fpmd_pkg::fpmd_work_t chain [0:fpmd_pkg::CELLS+1];
    logic        en;
    logic [fpmd_pkg::NUM_W-1:0] mag;
    logic [fpmd_pkg::NUM_W-1:0] qr;
    logic        ovf;
    logic        err_reg;
    logic        err_next;
    logic [31:0] res_reg;
    logic        ovf_reg;
    logic        vld_reg;
    fpmd_pkg::fpmd_work_t last;

    assign en            = !vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    fpmd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .operation (s_axis_tuser),
        .q         (chain[0])
    );

    fpmd_mult u_mult
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (chain[0]),
        .q     (chain[1])
    );

    for (genvar i = 0; i < fpmd_pkg::CELLS; i++)
    begin : g_cell
        fpmd_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .idx   (fpmd_pkg::IDX_W'(i)),
            .d     (chain[i+1]),
            .q     (chain[i+2])
        );
    end

    assign last = chain[fpmd_pkg::CELLS+1];

    always_comb
    begin
        ovf = last.ovf;
        if (last.is_make)
        begin
            qr = last.quo;
            if ({last.rem[fpmd_pkg::MAG_W-1:0], 1'b0} >= {1'b0, last.div})
                qr = last.quo + 64'd1;
            mag = qr;
            if (ovf || qr > 64'(fpmd_pkg::MAXV))
            begin
                ovf = 1'b1;
                mag = 64'(fpmd_pkg::MAXV);
            end
        end
        else
        begin
            qr  = 64'(last.ipart) + last.quo;
            mag = qr;
            if (qr > 64'(fpmd_pkg::MAXV))
            begin
                ovf = 1'b1;
                mag = 64'(fpmd_pkg::MAXV);
            end
        end
        err_next = err_reg | (last.valid & ovf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= last.valid;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= last.neg ? (32'd0 - mag[31:0]) : mag[31:0];
            ovf_reg <= ovf;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = {6'd0, err_reg, ovf_reg, res_reg};

endmodule

// ===== tb/fixed_point_mul_div_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed-point multiply/divide unit testbench
// drives make/take fraction and scaled operations through the stream ports,
// predicts each rounded or saturated result with a behavioral model and
// checks value, overflow and sticky error on every output beat
// ----------------------------------------------------------------------------
module fixed_point_mul_div_unit_tb;

    localparam longint unsigned MAX_MAG   = 64'h7FFF_FFFF;
    localparam int              CYC_LIMIT = 1000000;
    localparam int              DRAIN_CYC = 120;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
        logic        sticky;
    } fpmd_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    fpmd_result_t result_fifo[$];
    logic         sticky_model;
    int           mismatches;
    int           beats_in;
    int           beats_out;
    int           ovf_seen;
    int           cycle_cnt;
    bit           hold_req;
    bit           rx_no_idle;
    bit           tx_no_idle;
    int           op_count[4];

    fixed_point_mul_div_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned quotient_mag(longint unsigned p, longint unsigned q,
                                                     int k, ref logic ovf);
        longint unsigned num;
        longint unsigned quo;
        longint unsigned rem;
        if (q == 0)
        begin
            ovf = 1'b1;
            return MAX_MAG;
        end
        if (p / q >= (64'd1 << (31 - k)))
        begin
            ovf = 1'b1;
            return MAX_MAG;
        end
        num = p << k;
        quo = num / q;
        rem = num % q;
        if (2 * rem >= q)
            quo++;
        if (quo > MAX_MAG)
        begin
            ovf = 1'b1;
            return MAX_MAG;
        end
        return quo;
    endfunction

    function automatic longint unsigned product_mag(longint unsigned f, longint unsigned q,
                                                    int k, ref logic ovf);
        longint unsigned one;
        longint unsigned ip;
        longint unsigned p;
        one = 64'd1 << k;
        ip  = 0;
        if (f >= one)
        begin
            ip = f >> k;
            f  = f & (one - 1);
            if (q <= MAX_MAG / ip)
                ip = ip * q;
            else
            begin
                ovf = 1'b1;
                ip  = MAX_MAG;
            end
        end
        f = f + one;
        p = one >> 1;
        for (int i = 0; i < k; i++)
        begin
            if (f[0])
                p = (p + q) >> 1;
            else
                p = p >> 1;
            f = f >> 1;
        end
        if (ip + p > MAX_MAG)
        begin
            ovf = 1'b1;
            return MAX_MAG;
        end
        return ip + p;
    endfunction

    function automatic fpmd_result_t predict_mul_div(logic [1:0] op, logic [31:0] a,
                                                     logic [31:0] b);
        fpmd_result_t    r;
        logic            ovf;
        logic            neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mag;
        ovf = 1'b0;
        ma  = a[31] ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
        mb  = b[31] ? (64'h1_0000_0000 - {32'd0, b}) : {32'd0, b};
        if (op == fpmd_pkg::OP_MAKE_FRAC || op == fpmd_pkg::OP_MAKE_SCAL)
        begin
            neg = a[31] ^ (b[31] || mb == 0);
            mag = quotient_mag(ma, mb, (op == fpmd_pkg::OP_MAKE_FRAC) ?
                               fpmd_pkg::FRAC_BITS : fpmd_pkg::SCAL_BITS, ovf);
        end
        else
        begin
            neg = a[31] ^ b[31];
            mag = product_mag(ma, mb, (op == fpmd_pkg::OP_TAKE_FRAC) ?
                              fpmd_pkg::FRAC_BITS : fpmd_pkg::SCAL_BITS, ovf);
        end
        if (ovf)
            sticky_model = 1'b1;
        r.value  = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        r.ovf    = ovf;
        r.sticky = sticky_model;
        return r;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 0;
        else if (sel < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0: v = $urandom;
            1: v = $urandom_range(0, 600) - 300;
            2: v = $urandom_range(0, 32'hFFFF) << $urandom_range(0, 16);
            3: v = $urandom_range(1, 32'h3FFF_FFFF);
            4:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0001;
                    2: v = 32'h8000_0000;
                    3: v = 32'h1000_0000;
                    4: v = 32'h0001_0000;
                    default: v = 32'd0;
                endcase
                v = v + $urandom_range(0, 2) - 1;
            end
            default: v = $urandom_range(0, 32'h00FF_FFFF);
        endcase
        if ($urandom_range(0, 1))
            v = 32'd0 - v;
        return v;
    endfunction

    task automatic send_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        result_fifo.push_back(predict_mul_div(op, a, b));
        beats_in++;
        op_count[op]++;
        gap = tx_no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (result_fifo.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] edges[6];
        edges = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd0, 32'd1, 32'hFFFF_FFFF};
        for (int op = 0; op < 4; op++)
        begin
            send_item(op[1:0], 32'h1000_0000, 32'h0000_0003);
            send_item(op[1:0], 32'hF000_0000, 32'h0000_0007);
        end
        // zero divisor, both signs
        send_item(fpmd_pkg::OP_MAKE_FRAC, 32'd5, 32'd0);
        send_item(fpmd_pkg::OP_MAKE_SCAL, 32'hFFFF_FFFB, 32'd0);
        // quotient at and past the top
        send_item(fpmd_pkg::OP_MAKE_FRAC, 32'h7FFF_FFFF, 32'h1000_0000);
        send_item(fpmd_pkg::OP_MAKE_FRAC, 32'h7FFF_FFFF, 32'h0FFF_FFFF);
        send_item(fpmd_pkg::OP_MAKE_SCAL, 32'h8000_0000, 32'h0001_0000);
        // half-way rounding
        send_item(fpmd_pkg::OP_MAKE_SCAL, 32'd1, 32'h0002_0000);
        send_item(fpmd_pkg::OP_MAKE_SCAL, 32'hFFFF_FFFF, 32'h0002_0000);
        // product overflow and most negative operand
        send_item(fpmd_pkg::OP_TAKE_SCAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(fpmd_pkg::OP_TAKE_FRAC, 32'h8000_0000, 32'h8000_0000);
        for (int i = 0; i < 6; i++)
            send_item(fpmd_pkg::OP_TAKE_FRAC, edges[i], edges[5 - i]);
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_item(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
    endtask

    task automatic test_backpressure();
        tx_no_idle = 1'b1;
        hold_req   = 1'b1;
        test_random(150);
        tx_no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_streaming();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        test_random(200);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // receiver ready pattern
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_no_idle || gap_len() == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= 1'b0;
        end
    end

    // output beat checker
    always @(posedge clk)
    begin
        fpmd_result_t exp_r;
        fpmd_result_t got_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            got_r = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]};
            if (got_r.ovf)
                ovf_seen++;
            if (result_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %h ovf %b sticky %b",
                             got_r.value, got_r.ovf, got_r.sticky);
            end
            else
            begin
                exp_r = result_fifo.pop_front();
                if (exp_r.value !== got_r.value || exp_r.ovf !== got_r.ovf ||
                    exp_r.sticky !== got_r.sticky)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                 exp_r.value, exp_r.ovf, exp_r.sticky,
                                 got_r.value, got_r.ovf, got_r.sticky);
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYC_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        sticky_model  = 1'b0;
        mismatches    = 0;
        beats_in      = 0;
        beats_out     = 0;
        ovf_seen      = 0;
        hold_req      = 1'b0;
        rx_no_idle    = 1'b0;
        tx_no_idle    = 1'b0;
        op_count      = '{0, 0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_streaming();
        test_random(580);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);

        mismatches += result_fifo.size();
        $display("covered %0d beats in, %0d out, %0d saturated", beats_in, beats_out, ovf_seen);
        $display("ops: make_frac %0d take_frac %0d take_scal %0d make_scal %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
